// ----- design/bsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants of the motion mask block
// Frame geometry, blend weights, register indexes and the structs passed
// between the frame control, the background store and the pixel pipeline.
// ----------------------------------------------------------------------------
package bsm_pkg;

  // frame geometry
  localparam int unsigned FRAME_PIXELS = 307200;
  localparam int unsigned ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int unsigned FILL_W       = $clog2(FRAME_PIXELS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_PIXELS - 1);

  // pixel and register widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // 0.6 / 0.4 running average in 8 fractional bits, rounded half up
  localparam int unsigned WEIGHT_BG  = 154;
  localparam int unsigned WEIGHT_PIX = 102;
  localparam int unsigned ROUND_HALF = 128;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned ACC_W      = PIX_W + FRAC_W;

  // register reset values
  localparam logic [CFG_W-1:0] DIFF_THRESHOLD_RST = CFG_W'(20);
  localparam logic [CFG_W-1:0] BLEND_PERIOD_RST   = CFG_W'(10);
  localparam logic [CNT_W-1:0] CNT_MAX            = '1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THRESHOLD = 1'b0,
    CFG_BLEND_PERIOD   = 1'b1
  } cfg_idx_t;

  // frame control to pipeline
  typedef struct packed {
    addr_t addr;
    logic  blend;
  } frame_ctl_t;

  // store read request
  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

  // store write request
  typedef struct packed {
    logic  en;
    addr_t addr;
    pix_t  data;
  } mem_wr_t;

  // weighted blend of background and pixel, never above full scale
  function automatic pix_t blend_px(input pix_t bg, input pix_t pix);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(WEIGHT_BG) * ACC_W'(bg) + ACC_W'(WEIGHT_PIX) * ACC_W'(pix)
        + ACC_W'(ROUND_HALF);
    return acc[ACC_W-1:FRAC_W];
  endfunction

endpackage

// ----- design/bsm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pix_if / bsm_mask_if: valid-ready channels of the motion mask block
// Pixel beats in, mask beats out.
// ----------------------------------------------------------------------------
interface bsm_pix_if;
  logic                   valid;
  logic                   ready;
  logic [bsm_pkg::PIX_W-1:0] pixel_value;
  logic                   frame_last;

  modport source (output valid, output pixel_value, output frame_last, input ready);
  modport sink   (input valid, input pixel_value, input frame_last, output ready);
endinterface

interface bsm_mask_if;
  logic valid;
  logic ready;
  logic motion_flag;
  logic mask_last;

  modport source (output valid, output motion_flag, output mask_last, input ready);
  modport sink   (input valid, input motion_flag, input mask_last, output ready);
endinterface

// ----- design/bsm_frame_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_frame_ctrl: pixel address and per-frame blend decision
// Tracks the raster position and decides at each frame start whether this
// frame is blended into the background.
// ----------------------------------------------------------------------------
module bsm_frame_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat_acc,
  input  logic                          frame_last,
  input  logic [bsm_pkg::CNT_W-1:0]     blend_period,
  output bsm_pkg::frame_ctl_t           ctl
);
  import bsm_pkg::*;

  addr_t            addr_r, addr_nxt;
  logic [CNT_W-1:0] frames_r, frames_nxt;
  logic             blend_r, blend_nxt;
  logic             frame_start;

  // decision for the current beat, taken at frame start
  always_comb begin
    frame_start = (addr_r == '0);
    frames_nxt  = frames_r;
    blend_nxt   = blend_r;
    if (frame_start) begin
      if (frames_r > blend_period) begin
        blend_nxt  = 1'b1;
        frames_nxt = '0;
      end else begin
        blend_nxt = 1'b0;
        if (frames_r != CNT_MAX) begin
          frames_nxt = frames_r + CNT_W'(1);
        end
      end
    end
    // short frame ends on the marker, long frame wraps
    if (frame_last || addr_r == LAST_ADDR) begin
      addr_nxt = '0;
    end else begin
      addr_nxt = addr_r + ADDR_W'(1);
    end
  end

  assign ctl.addr  = addr_r;
  assign ctl.blend = blend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      frames_r <= '0;
      blend_r  <= 1'b0;
    end else if (beat_acc) begin
      addr_r   <= addr_nxt;
      frames_r <= frames_nxt;
      blend_r  <= blend_nxt;
    end
  end

endmodule

// ----- design/bsm_bg_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_bg_store: background frame memory
// One read and one write port, registered read. A fill count marks the
// entries written since reset; all others read as zero. A write landing on
// the address read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module bsm_bg_store (
  input  logic             clk,
  input  logic             rst_n,
  input  bsm_pkg::mem_rd_t rd,
  input  bsm_pkg::mem_wr_t wr,
  output bsm_pkg::pix_t    rd_data
);
  import bsm_pkg::*;

  pix_t              mem [FRAME_PIXELS];
  pix_t              rd_data_r;
  pix_t              fwd_data_r;
  logic              fwd_r;
  logic              hit_r;
  logic [FILL_W-1:0] fill_r;

  // memory array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // forwarding and written-entry check, captured with the read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd_r      <= wr.en && (wr.addr == rd.addr);
      fwd_data_r <= wr.data;
      hit_r      <= (FILL_W'(rd.addr) < fill_r);
    end
  end

  // blend frames write from address zero upward, so one count covers it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr.en && FILL_W'(wr.addr) == fill_r) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (hit_r ? rd_data_r : '0);

endmodule

// ----- design/background_subtraction_motion_mask.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_subtraction_motion_mask: running-average motion mask
// Compares each grey pixel with a stored background and flags motion.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock unless the mask side stalls, and each
// gives one mask beat. The rate is set by the background memory, which does
// one read (at accept) and one write-back (when the pixel leaves the blend
// stage) per cycle. The mask output is registered; while a mask beat waits the
// blend stage still takes one more pixel beat, then the input holds until the
// mask side takes a beat. The background starts as all zero after reset without
// a clearing pass: a fill count tracks entries already written. Registers must
// be written only while no pixel is in flight; the block does not enforce it.
module background_subtraction_motion_mask (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0]         cfg_wdata,
  bsm_pix_if.sink                           in_px,
  bsm_mask_if.source                        out_mask
);
  import bsm_pkg::*;

  logic [CFG_W-1:0] thr_r;
  logic [CFG_W-1:0] period_r;

  frame_ctl_t ctl;
  mem_rd_t    rd_req;
  mem_wr_t    wr_req;
  pix_t       bg_rd;

  logic  acc;
  logic  s1_valid_r;
  pix_t  s1_pix_r;
  logic  s1_last_r;
  logic  s1_blend_r;
  addr_t s1_addr_r;
  logic  s1_move;
  logic  s2_free;

  pix_t  blended;
  pix_t  bg_now;
  pix_t  diff;
  logic  flag;

  logic  out_valid_r;
  logic  out_flag_r;
  logic  out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= DIFF_THRESHOLD_RST;
      period_r <= BLEND_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIFF_THRESHOLD: thr_r    <= cfg_wdata;
        CFG_BLEND_PERIOD:   period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake and stage advance
  assign s2_free      = !out_valid_r || out_mask.ready;
  assign s1_move      = s1_valid_r && s2_free;
  assign in_px.ready  = !s1_valid_r || s2_free;
  assign acc          = in_px.valid && in_px.ready;

  bsm_frame_ctrl u_frame_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_acc     (acc),
    .frame_last   (in_px.frame_last),
    .blend_period (period_r),
    .ctl          (ctl)
  );

  // memory requests: read at accept, write back when the blend stage moves on
  assign rd_req.en   = acc;
  assign rd_req.addr = ctl.addr;
  assign wr_req.en   = s1_move && s1_blend_r;
  assign wr_req.addr = s1_addr_r;
  assign wr_req.data = blended;

  bsm_bg_store u_bg_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd_req),
    .wr      (wr_req),
    .rd_data (bg_rd)
  );

  // blend stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_blend_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
        s1_blend_r <= ctl.blend;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_px.pixel_value;
      s1_last_r <= in_px.frame_last;
      s1_addr_r <= ctl.addr;
    end
  end

  // running average and threshold compare
  always_comb begin
    blended = blend_px(bg_rd, s1_pix_r);
    bg_now  = s1_blend_r ? blended : bg_rd;
    diff    = (bg_now >= s1_pix_r) ? (bg_now - s1_pix_r) : (s1_pix_r - bg_now);
    flag    = (diff > thr_r);
  end

  // mask output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_flag_r <= flag;
      out_last_r <= s1_last_r;
    end
  end

  assign out_mask.valid       = out_valid_r;
  assign out_mask.motion_flag = out_flag_r;
  assign out_mask.mask_last   = out_last_r;

  // a frame marker always sends the next beat to address zero
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_px.frame_last |=> ctl.addr == '0)
    else $error("address not zero after frame marker");

  // blend decision only changes at a frame start
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && ctl.addr != '0 |-> ctl.blend == s1_blend_r)
    else $error("blend decision changed inside a frame");

  // a mask beat only appears from an occupied blend stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("mask beat without a pixel in the blend stage");

endmodule
